// File: hw/rtl/hgbl_pkg.sv
package hgbl_pkg;

  localparam int VAL_W        = 48;
  localparam int DIM_REG_W    = 9;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_W        = 48;
  localparam int MAX_COLS_DEF = 256;
  localparam int MAX_ROWS_DEF = 256;

  // Blank sample code 980000.0 in Q32.16
  localparam logic signed [VAL_W-1:0] BLANK_Q16    = 48'sd64225280000;
  localparam logic [VAL_W-1:0]        INV_STEP_RST = 48'h0001_0000_0000;
  localparam logic [DIM_REG_W-1:0]    DIM_RST      = 9'd2;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_QUERY = 2'd1,
    REQ_FILL  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLS  = 3'd0,
    CFG_ROWS  = 3'd1,
    CFG_ORG_X = 3'd2,
    CFG_ORG_Y = 3'd3,
    CFG_INV_X = 3'd4,
    CFG_INV_Y = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_FIX,
    ST_ADDR,
    ST_READ,
    ST_LMUL,
    ST_LADD,
    ST_FILL
  } state_t;

endpackage

// File: hw/rtl/hgbl_in_if.sv
interface hgbl_in_if import hgbl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              req_type;
  logic signed [VAL_W-1:0] sample_value;
  logic                    first_sample;
  logic signed [VAL_W-1:0] query_x;
  logic signed [VAL_W-1:0] query_y;

  modport source (output valid, req_type, sample_value, first_sample, query_x, query_y,
                  input ready);
  modport sink (input valid, req_type, sample_value, first_sample, query_x, query_y,
                output ready);
endinterface

// File: hw/rtl/hgbl_out_if.sv
interface hgbl_out_if import hgbl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] z_value;
  logic signed [VAL_W-1:0] min_value;
  logic signed [VAL_W-1:0] max_value;
  logic                    dropped;

  modport source (output valid, z_value, min_value, max_value, dropped, input ready);
  modport sink (input valid, z_value, min_value, max_value, dropped, output ready);
endinterface

// File: hw/rtl/height_grid_bilinear_lookup.sv
// Channel   | Dir | Transfer when        | Carries
// in_ch     | in  | valid & ready        | req_type, sample_value, first_sample, query_x/y
// out_ch    | out | valid & ready        | z_value, min_value, max_value, dropped
// cfg_*     | in  | cfg_we (no backpress)| register index and write data
//
// Load: written in the accept cycle, result in the cycle after.
// Query: six products on one 32x32 multiplier,
//   four reads from the single-port grid memory, three lerps on one 49x17 multiplier.
// Fill: writes sample_value to all rows*cols cells, one grid write per cycle.
// Reset clears control and configuration registers; grid contents stay undefined until written.
// One item in flight; input holds off while a result waits on the output register.
module height_grid_bilinear_lookup import hgbl_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  hgbl_in_if.sink              in_ch,
  hgbl_out_if.source           out_ch
);

  localparam int CW    = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int AW    = CW + RW;
  localparam int CDW   = CW + 1;
  localparam int RDW   = RW + 1;
  localparam int TW    = AW + 1;
  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int FW    = CW + 16;
  localparam int GW    = RW + 16;
  localparam int ACCW  = 51;

  // Configuration registers
  logic [DIM_REG_W-1:0]    cols_cfg_r, rows_cfg_r;
  logic signed [VAL_W-1:0] org_x_r, org_y_r;
  logic [VAL_W-1:0]        inv_x_r, inv_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_cfg_r <= DIM_RST;
      rows_cfg_r <= DIM_RST;
      org_x_r    <= '0;
      org_y_r    <= '0;
      inv_x_r    <= INV_STEP_RST;
      inv_y_r    <= INV_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_COLS:  cols_cfg_r <= cfg_wdata[DIM_REG_W-1:0];
        CFG_ROWS:  rows_cfg_r <= cfg_wdata[DIM_REG_W-1:0];
        CFG_ORG_X: org_x_r    <= cfg_wdata[VAL_W-1:0];
        CFG_ORG_Y: org_y_r    <= cfg_wdata[VAL_W-1:0];
        CFG_INV_X: inv_x_r    <= cfg_wdata[VAL_W-1:0];
        CFG_INV_Y: inv_y_r    <= cfg_wdata[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp grid size to [2, MAX]
  logic [CDW-1:0] cols_eff;
  logic [RDW-1:0] rows_eff;

  always_comb begin
    if (cols_cfg_r < 9'd2) begin
      cols_eff = CDW'(2);
    end else if (32'(cols_cfg_r) > 32'(MAX_COLS)) begin
      cols_eff = CDW'(MAX_COLS);
    end else begin
      cols_eff = CDW'(cols_cfg_r);
    end
    if (rows_cfg_r < 9'd2) begin
      rows_eff = RDW'(2);
    end else if (32'(rows_cfg_r) > 32'(MAX_ROWS)) begin
      rows_eff = RDW'(MAX_ROWS);
    end else begin
      rows_eff = RDW'(rows_cfg_r);
    end
  end

  // Control and datapath state
  state_t state_r, state_nxt;

  logic [RW-1:0]           load_row_r;
  logic [CDW-1:0]          load_col_r;
  logic signed [VAL_W-1:0] min_r, max_r;
  logic                    mm_valid_r;

  logic                    out_valid_r;
  logic signed [VAL_W-1:0] out_z_r, out_min_r, out_max_r;
  logic                    out_drop_r;

  logic signed [VAL_W-1:0] val_r;
  logic signed [VAL_W:0]   dx_r, dy_r;
  logic [2:0]              step_r;
  logic [63:0]             prod_r;
  logic [ACCW-1:0]         acc_x_r, acc_y_r;
  logic [CW-1:0]           i0_r, i1_r;
  logic [RW-1:0]           j0_r, j1_r;
  logic [15:0]             tx_r, ty_r;
  logic [AW-1:0]           base0_r, base1_r;
  logic [2:0]              rd_cnt_r;
  logic signed [VAL_W-1:0] v_r [4];
  logic [1:0]              lphase_r;
  logic signed [65:0]      lprod_r;
  logic signed [VAL_W-1:0] top_r, bot_r;
  logic [TW-1:0]           fill_addr_r, total_r;

  logic in_xfer;
  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // Load path: position, blank code and drop check in the accept cycle
  logic [RW-1:0]           row_st;
  logic [CDW-1:0]          col_st;
  logic                    mm_valid_st;
  logic signed [VAL_W-1:0] min_st, max_st, ld_val, min_new, max_new;
  logic                    ld_drop;
  logic [AW:0]             ld_prod;
  logic [AW-1:0]           ld_addr;

  always_comb begin
    row_st      = in_ch.first_sample ? '0 : load_row_r;
    col_st      = in_ch.first_sample ? '0 : load_col_r;
    mm_valid_st = in_ch.first_sample ? 1'b0 : mm_valid_r;
    min_st      = in_ch.first_sample ? '0 : min_r;
    max_st      = in_ch.first_sample ? '0 : max_r;
    ld_drop     = (col_st >= cols_eff) || (RDW'(row_st) >= rows_eff);
    ld_val      = (in_ch.sample_value == BLANK_Q16) ? '0 : in_ch.sample_value;
    ld_prod     = row_st * cols_eff;
    ld_addr     = AW'(ld_prod + (AW+1)'(col_st));
    if (!mm_valid_st) begin
      min_new = ld_val;
      max_new = ld_val;
    end else begin
      min_new = (ld_val < min_st) ? ld_val : min_st;
      max_new = (ld_val > max_st) ? ld_val : max_st;
    end
  end

  // Shared 32x32 multiplier operands for the fractional index
  logic [31:0] mul_a, mul_b;

  always_comb begin
    case (step_r)
      3'd0:    begin mul_a = dx_r[31:0];           mul_b = inv_x_r[31:0]; end
      3'd1:    begin mul_a = 32'(dx_r[47:32]);     mul_b = inv_x_r[31:0]; end
      3'd2:    begin mul_a = dx_r[31:0];           mul_b = 32'(inv_x_r[47:32]); end
      3'd3:    begin mul_a = dy_r[31:0];           mul_b = inv_y_r[31:0]; end
      3'd4:    begin mul_a = 32'(dy_r[47:32]);     mul_b = inv_y_r[31:0]; end
      3'd5:    begin mul_a = dy_r[31:0];           mul_b = 32'(inv_y_r[47:32]); end
      default: begin mul_a = '0;                   mul_b = '0; end
    endcase
  end

  // Clamp to the grid and split into cell index and fraction
  logic          neg_x, neg_y, sat_x, sat_y;
  logic [FW-1:0] lim_x, fi;
  logic [GW-1:0] lim_y, fj;
  logic [CW-1:0] i0;
  logic [RW-1:0] j0;
  logic [CDW-1:0] i0p;
  logic [RDW-1:0] j0p;

  always_comb begin
    neg_x = dx_r[VAL_W] || (dx_r == '0);
    neg_y = dy_r[VAL_W] || (dy_r == '0);
    sat_x = (dx_r[47:32] != '0) && (inv_x_r[47:32] != '0);
    sat_y = (dy_r[47:32] != '0) && (inv_y_r[47:32] != '0);
    lim_x = {CW'(cols_eff - CDW'(1)), 16'h0000};
    lim_y = {RW'(rows_eff - RDW'(1)), 16'h0000};
    if (neg_x) begin
      fi = '0;
    end else if (sat_x || (acc_x_r > ACCW'(lim_x))) begin
      fi = lim_x;
    end else begin
      fi = FW'(acc_x_r);
    end
    if (neg_y) begin
      fj = '0;
    end else if (sat_y || (acc_y_r > ACCW'(lim_y))) begin
      fj = lim_y;
    end else begin
      fj = GW'(acc_y_r);
    end
    i0  = fi[16 +: CW];
    j0  = fj[16 +: RW];
    i0p = CDW'(i0) + CDW'(1);
    j0p = RDW'(j0) + RDW'(1);
  end

  // Lerp operands: top row, bottom row, then between the two
  logic signed [VAL_W-1:0] la, lb;
  logic [15:0]             lt;
  logic signed [VAL_W:0]   ldiff;
  logic signed [16:0]      lt_s;
  logic signed [VAL_W-1:0] lres;

  always_comb begin
    case (lphase_r)
      2'd0:    begin la = v_r[0]; lb = v_r[1]; lt = tx_r; end
      2'd1:    begin la = v_r[2]; lb = v_r[3]; lt = tx_r; end
      default: begin la = top_r;  lb = bot_r;  lt = ty_r; end
    endcase
    ldiff = {lb[VAL_W-1], lb} - {la[VAL_W-1], la};
    lt_s  = {1'b0, lt};
    // floor(diff*t / 2^16) added to a, kept to 48 bits
    lres  = la + lprod_r[63:16];
  end

  // Grid memory port
  logic             mem_we;
  logic [AW-1:0]    mem_addr;
  logic [VAL_W-1:0] mem_wdata, mem_rdata;

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = '0;
    mem_wdata = ld_val;
    unique case (state_r)
      ST_IDLE: begin
        mem_addr = ld_addr;
        mem_we   = in_xfer && (in_ch.req_type == REQ_LOAD) && !ld_drop;
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_addr  = fill_addr_r[AW-1:0];
        mem_wdata = val_r;
      end
      ST_READ: begin
        case (rd_cnt_r)
          3'd0:    mem_addr = base0_r + AW'(i0_r);
          3'd1:    mem_addr = base0_r + AW'(i1_r);
          3'd2:    mem_addr = base1_r + AW'(i0_r);
          default: mem_addr = base1_r + AW'(i1_r);
        endcase
      end
      default: ;
    endcase
  end

  hgbl_grid_mem #(.AW(AW), .DEPTH(DEPTH)) u_grid_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_ch.req_type)
            REQ_QUERY: state_nxt = ST_MUL;
            REQ_FILL:  state_nxt = ST_FILL;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_MUL:  if (step_r == 3'd6) state_nxt = ST_FIX;
      ST_FIX:  state_nxt = ST_ADDR;
      ST_ADDR: state_nxt = ST_READ;
      ST_READ: if (rd_cnt_r == 3'd4) state_nxt = ST_LMUL;
      ST_LMUL: state_nxt = ST_LADD;
      ST_LADD: state_nxt = (lphase_r == 2'd2) ? ST_IDLE : ST_LMUL;
      ST_FILL: if (fill_addr_r == total_r - TW'(1)) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control registers: load position, running min/max, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_row_r  <= '0;
      load_col_r  <= '0;
      min_r       <= '0;
      max_r       <= '0;
      mm_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      rd_cnt_r    <= '0;
      lphase_r    <= '0;
      fill_addr_r <= '0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          step_r      <= '0;
          rd_cnt_r    <= '0;
          lphase_r    <= '0;
          fill_addr_r <= '0;
          if (in_xfer && (in_ch.req_type == REQ_LOAD)) begin
            out_valid_r <= 1'b1;
            if (ld_drop) begin
              load_row_r <= row_st;
              load_col_r <= col_st;
              min_r      <= min_st;
              max_r      <= max_st;
              mm_valid_r <= mm_valid_st;
            end else begin
              min_r      <= min_new;
              max_r      <= max_new;
              mm_valid_r <= 1'b1;
              if (RDW'(row_st) + RDW'(1) >= rows_eff) begin
                load_row_r <= '0;
                load_col_r <= col_st + CDW'(1);
              end else begin
                load_row_r <= row_st + RW'(1);
                load_col_r <= col_st;
              end
            end
          end else if (in_xfer && (in_ch.req_type == REQ_NONE)) begin
            out_valid_r <= 1'b1;
          end
        end
        ST_MUL:  step_r   <= step_r + 3'd1;
        ST_READ: rd_cnt_r <= rd_cnt_r + 3'd1;
        ST_LADD: begin
          lphase_r <= lphase_r + 2'd1;
          if (lphase_r == 2'd2) begin
            out_valid_r <= 1'b1;
          end
        end
        ST_FILL: begin
          fill_addr_r <= fill_addr_r + TW'(1);
          if (fill_addr_r == total_r - TW'(1)) begin
            out_valid_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        val_r   <= in_ch.sample_value;
        dx_r    <= {in_ch.query_x[VAL_W-1], in_ch.query_x} - {org_x_r[VAL_W-1], org_x_r};
        dy_r    <= {in_ch.query_y[VAL_W-1], in_ch.query_y} - {org_y_r[VAL_W-1], org_y_r};
        total_r <= TW'(rows_eff) * TW'(cols_eff);
        if (in_xfer && (in_ch.req_type == REQ_LOAD)) begin
          out_z_r    <= '0;
          out_drop_r <= ld_drop;
          out_min_r  <= ld_drop ? min_st : min_new;
          out_max_r  <= ld_drop ? max_st : max_new;
        end else if (in_xfer && (in_ch.req_type == REQ_NONE)) begin
          out_z_r    <= '0;
          out_drop_r <= 1'b0;
          out_min_r  <= min_r;
          out_max_r  <= max_r;
        end
      end
      ST_MUL: begin
        prod_r <= mul_a * mul_b;
        // accumulate the product launched one step earlier
        case (step_r)
          3'd1: acc_x_r <= ACCW'(prod_r[63:32]);
          3'd2: acc_x_r <= acc_x_r + prod_r[ACCW-1:0];
          3'd3: acc_x_r <= acc_x_r + prod_r[ACCW-1:0];
          3'd4: acc_y_r <= ACCW'(prod_r[63:32]);
          3'd5: acc_y_r <= acc_y_r + prod_r[ACCW-1:0];
          3'd6: acc_y_r <= acc_y_r + prod_r[ACCW-1:0];
          default: ;
        endcase
      end
      ST_FIX: begin
        i0_r <= i0;
        j0_r <= j0;
        i1_r <= (i0p < cols_eff) ? CW'(i0p) : CW'(cols_eff - CDW'(1));
        j1_r <= (j0p < rows_eff) ? RW'(j0p) : RW'(rows_eff - RDW'(1));
        tx_r <= fi[15:0];
        ty_r <= fj[15:0];
      end
      ST_ADDR: begin
        base0_r <= AW'(j0_r) * AW'(cols_eff);
        base1_r <= AW'(j1_r) * AW'(cols_eff);
      end
      ST_READ: begin
        if (rd_cnt_r != 3'd0) begin
          v_r[2'(rd_cnt_r - 3'd1)] <= mem_rdata;
        end
      end
      ST_LMUL: lprod_r <= ldiff * lt_s;
      ST_LADD: begin
        case (lphase_r)
          2'd0: top_r <= lres;
          2'd1: bot_r <= lres;
          default: begin
            out_z_r    <= lres;
            out_drop_r <= 1'b0;
            out_min_r  <= min_r;
            out_max_r  <= max_r;
          end
        endcase
      end
      ST_FILL: begin
        if (fill_addr_r == total_r - TW'(1)) begin
          out_z_r    <= '0;
          out_drop_r <= 1'b0;
          out_min_r  <= min_r;
          out_max_r  <= max_r;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.z_value   = out_z_r;
  assign out_ch.min_value = out_min_r;
  assign out_ch.max_value = out_max_r;
  assign out_ch.dropped   = out_drop_r;

endmodule

// File: hw/rtl/hgbl_grid_mem.sv
module hgbl_grid_mem import hgbl_pkg::*; #(
  parameter int AW    = 16,
  parameter int DEPTH = 65536
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [VAL_W-1:0] wdata,
  output logic [VAL_W-1:0] rdata
);

  logic [VAL_W-1:0] mem [0:DEPTH-1];
  logic [VAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/hgbl_checker.sv
module hgbl_checker import hgbl_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [VAL_W-1:0] z_value,
  input logic signed [VAL_W-1:0] min_value,
  input logic signed [VAL_W-1:0] max_value,
  input logic                    dropped
);

  // Hold a result until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  // Drop a load only with a zero height
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && dropped |-> z_value == '0)
    else $error("dropped result carries a height");

  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> min_value <= max_value)
    else $error("running minimum above maximum");

  // No new item while a result waits
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind height_grid_bilinear_lookup hgbl_checker u_hgbl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .z_value   (out_ch.z_value),
  .min_value (out_ch.min_value),
  .max_value (out_ch.max_value),
  .dropped   (out_ch.dropped)
);
